// File: hdl/assert_macros.svh
// assertion macros shared by the checker files
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define MCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs through reset
`define MCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/mcc_pkg.sv
// shared types and constants for the fewest-coins change block
// no dependencies
`default_nettype none

package mcc_pkg;

    localparam int AMT_W           = 10;  // amount and table index width
    localparam int CNT_W           = 10;  // coin count width
    localparam int COIN_W          = 10;  // denomination width
    localparam int CCNT_W          = 3;   // coin_count register width
    localparam int ENTRY_W         = CNT_W + 1;  // reachable bit over count
    localparam int NUM_COIN_REGS   = 4;
    localparam int COIN_IDX_W      = 2;
    localparam int MAX_COINS       = 4;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int CFG_IDX_W       = 3;

    // register reset values
    localparam logic [COIN_W-1:0] COIN_RST [NUM_COIN_REGS] = '{
        10'd25, 10'd10, 10'd5, 10'd1
    };
    localparam logic [CCNT_W-1:0] COIN_COUNT_RST = 3'd4;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COIN_A     = 3'd0,
        REG_COIN_B     = 3'd1,
        REG_COIN_C     = 3'd2,
        REG_COIN_D     = 3'd3,
        REG_COIN_COUNT = 3'd4
    } t_cfg_reg;

    // controller to datapath commands
    typedef struct packed {
        logic                  load;
        logic                  init;
        logic                  issue;
        logic                  write;
        logic                  done;
        logic [COIN_IDX_W-1:0] coin_idx;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic              amt_zero;
        logic              oversize;
        logic              last_v;
        logic [CCNT_W-1:0] used;
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/mcc_ctrl.sv
// sequencer for the table fill: walks entries and coins, issues commands
// depends on mcc_pkg
`default_nettype none

module mcc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire mcc_pkg::t_sts i_sts,
    output mcc_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import mcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ISSUE,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_busy;
    logic [COIN_IDX_W-1:0] r_k;

    // state, busy flag and coin index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start && !r_busy) begin
                        r_state <= S_INIT;
                        r_busy  <= 1'b1;
                    end
                end
                S_INIT: begin
                    r_k <= '0;
                    if (i_sts.oversize || i_sts.amt_zero) begin
                        r_state <= S_DONE;
                    end else if (i_sts.used == '0) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (CCNT_W'(r_k) + 3'd1 == i_sts.used) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_k <= '0;
                    if (i_sts.last_v) begin
                        r_state <= S_DONE;
                    end else if (i_sts.used == '0) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start && !r_busy;
        o_cmd.init     = (r_state == S_INIT);
        o_cmd.issue    = (r_state == S_ISSUE);
        o_cmd.write    = (r_state == S_WRITE);
        o_cmd.done     = (r_state == S_DONE);
        o_cmd.coin_idx = r_k;
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// File: hdl/mcc_dp.sv
// datapath: coin registers, best-count table memory, min search, result regs
// depends on mcc_pkg
`default_nettype none

module mcc_dp #(
    parameter int TABLE_DEPTH = mcc_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [mcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mcc_pkg::COIN_W-1:0]     i_cfg_data,
    input  wire logic [mcc_pkg::AMT_W-1:0]      i_amount,
    input  wire mcc_pkg::t_cmd                  i_cmd,
    output mcc_pkg::t_sts                       o_sts,
    output logic                                o_result_valid,
    output logic [mcc_pkg::CNT_W-1:0]           o_min_count,
    output logic                                o_unreachable
);
    import mcc_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COIN_W-1:0]  r_coin [NUM_COIN_REGS];
    logic [CCNT_W-1:0]  r_coin_count;
    logic [AMT_W-1:0]   r_amount;
    logic [AMT_W-1:0]   r_v;
    logic               r_found;
    logic [ENTRY_W-1:0] r_best;
    logic               r_rd_valid;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_last;
    logic               r_strobe;
    logic [CNT_W-1:0]   r_min_count;
    logic               r_unreach;
    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];

    logic [CCNT_W-1:0]  used_cnt;
    logic [COIN_W-1:0]  coin_sel;
    logic               coin_ok;
    logic [AMT_W-1:0]   diff;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               mem_we;
    logic [ENTRY_W-1:0] cand;
    logic               take;
    logic               acc_found;
    logic [ENTRY_W-1:0] acc_best;
    logic [CNT_W-1:0]   sat_cnt;
    logic [ENTRY_W-1:0] entry;
    logic               oversize;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin       <= COIN_RST;
            r_coin_count <= COIN_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_COIN_A:     r_coin[0]    <= i_cfg_data;
                REG_COIN_B:     r_coin[1]    <= i_cfg_data;
                REG_COIN_C:     r_coin[2]    <= i_cfg_data;
                REG_COIN_D:     r_coin[3]    <= i_cfg_data;
                REG_COIN_COUNT: r_coin_count <= i_cfg_data[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // number of denominations in use, clipped to the register count
    always_comb begin
        used_cnt = r_coin_count;
        if (used_cnt > CCNT_W'(MAX_COINS)) begin
            used_cnt = CCNT_W'(MAX_COINS);
        end
        if (used_cnt > CCNT_W'(NUM_COIN_REGS)) begin
            used_cnt = CCNT_W'(NUM_COIN_REGS);
        end
    end

    // coin select and lookup address for the current entry
    assign coin_sel = r_coin[i_cmd.coin_idx];
    assign coin_ok  = (CCNT_W'(i_cmd.coin_idx) < used_cnt) && (coin_sel != '0)
                      && (coin_sel <= r_v);
    assign diff     = r_v - coin_sel;
    assign rd_addr  = AW'(diff);

    // running minimum over the looked-up entries
    assign cand      = {1'b0, r_rd_data[CNT_W-1:0]} + 11'd1;
    assign take      = r_rd_valid && r_rd_data[CNT_W] && (!r_found || (cand < r_best));
    assign acc_found = r_found | take;
    assign acc_best  = take ? cand : r_best;
    assign sat_cnt   = acc_best[CNT_W] ? {CNT_W{1'b1}} : acc_best[CNT_W-1:0];
    assign entry     = acc_found ? {1'b1, sat_cnt} : '0;

    // table write: entry zero on init, the current entry on write
    assign mem_we  = i_cmd.init | i_cmd.write;
    assign wr_addr = i_cmd.init ? '0 : AW'(r_v);
    assign wr_data = i_cmd.init ? {1'b1, {CNT_W{1'b0}}} : entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign oversize = ({7'd0, r_amount} >= 17'(TABLE_DEPTH));

    // fill sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_rd_valid <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.issue) begin
                r_rd_valid <= coin_ok;
                r_found    <= acc_found;
            end else if (i_cmd.write) begin
                r_rd_valid <= 1'b0;
                r_found    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_amount <= i_amount;
        end
        if (i_cmd.init) begin
            r_v    <= AMT_W'(1);
            r_last <= {1'b1, {CNT_W{1'b0}}};
        end else if (i_cmd.issue) begin
            r_best <= acc_best;
        end else if (i_cmd.write) begin
            r_v    <= r_v + 1'b1;
            r_last <= entry;
        end
    end

    // result word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_min_count <= (!oversize && r_last[CNT_W]) ? r_last[CNT_W-1:0] : '0;
            r_unreach   <= oversize || !r_last[CNT_W];
        end
    end

    // status back to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.amt_zero = (r_amount == '0);
        o_sts.oversize = oversize;
        o_sts.last_v   = (r_v == r_amount);
        o_sts.used     = used_cnt;
    end

    assign o_result_valid = r_strobe;
    assign o_min_count    = r_min_count;
    assign o_unreachable  = r_unreach;

endmodule

`default_nettype wire

// File: hdl/min_coin_change_core.sv
// top level of the fewest-coins change block: controller plus datapath
// depends on mcc_pkg, mcc_ctrl, mcc_dp
//
//  channel   handshake                      word
//  -------   ---------------------------    ---------------------------------
//  command   start / busy                   i_amount
//  result    o_result_valid (1-cycle pulse) o_min_count, o_unreachable
//  config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  an item runs from accept through init, then the table fill, then done and
//  the result strobe; the fill does one lookup per coin in use per entry plus
//  one write per entry. amount zero, or an amount past the table, skips the
//  table fill and goes from init straight to done.
//  synchronous active-low reset; the table needs no clearing since every item
//  rewrites the entries it reads. results cannot be stalled by the receiver.
`default_nettype none

module min_coin_change_core #(
    parameter int TABLE_DEPTH = mcc_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mcc_pkg::AMT_W-1:0]      i_amount,
    output logic                                o_result_valid,
    output logic [mcc_pkg::CNT_W-1:0]           o_min_count,
    output logic                                o_unreachable,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mcc_pkg::COIN_W-1:0]     i_cfg_data
);
    import mcc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // registers always take configuration writes
    assign o_cfg_ready = 1'b1;

    mcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mcc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_amount       (i_amount),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_min_count    (o_min_count),
        .o_unreachable  (o_unreachable)
    );

endmodule

`default_nettype wire

// File: hdl/mcc_checker.sv
// port-level checks on the fewest-coins change block, bound to its top level
// depends on assert_macros.svh and min_coin_change_core
`default_nettype none
`include "assert_macros.svh"

module mcc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_result_valid
);

    // reset leaves the block idle with no result pending
    `MCC_ASSERT_RST(a_reset_idle, !i_rst_n |=> !busy && !o_result_valid, "not idle after reset")

    // an accepted command makes the block busy
    `MCC_ASSERT(a_accept_busy, start && !busy |=> busy, "busy not raised on accept")

    // a result word only comes as the block finishes
    `MCC_ASSERT(a_result_at_end, o_result_valid |-> $fell(busy), "result without end of work")

    // every finished item delivers a result word
    `MCC_ASSERT(a_end_has_result, $past(i_rst_n) && $fell(busy) |-> o_result_valid, "work ended without result")

    // busy and a result word are never shown together
    `MCC_ASSERT(a_no_result_busy, o_result_valid |-> !busy, "result while busy")

endmodule

bind min_coin_change_core mcc_checker u_mcc_checker (.*);

`default_nettype wire

// File: tb/tb_min_coin_change_core.sv
`timescale 1ns / 100ps
// testbench for min_coin_change_core: directed and random amounts over changing
// denominations, each result checked against a bottom-up table predictor
// depends on mcc_pkg and min_coin_change_core

module tb_min_coin_change_core;
    import mcc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 11;
    localparam int TAIL_CYCLES = 16;
    localparam int RAND_ITEMS  = 110;
    // slowest correct run: every word at the largest amount with all coins in use,
    // plus the longest gap, taken several times over
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;

    // register indexes outside the map, writes to them are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        OP_AMOUNT,
        OP_WRITE,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [AMT_W-1:0]      amount;
        logic [CFG_IDX_W-1:0]  idx;
        logic [COIN_W-1:0]     data;
        logic [15:0]           gap;
    } t_pending_op;

    typedef struct packed {
        logic [CNT_W-1:0] min_count;
        logic             unreachable;
    } t_change;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [AMT_W-1:0]      i_amount       = '0;
    logic                  o_result_valid;
    logic [CNT_W-1:0]      o_min_count;
    logic                  o_unreachable;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [COIN_W-1:0]     i_cfg_data     = '0;

    // predictor copy of the registers and the table
    logic [COIN_W-1:0]     coin_q [NUM_COIN_REGS];
    logic [CCNT_W-1:0]     coin_count_q;
    logic [ENTRY_W-1:0]    best_coins [DEF_TABLE_DEPTH];

    t_pending_op           pending_q [$];
    t_change               expected_change_q [$];
    t_pending_op           cur_op;
    logic                  op_loaded      = 1'b0;
    logic                  op_issued      = 1'b0;
    int                    gap_left       = 0;
    int                    error_count    = 0;
    int                    cycle_count    = 0;
    bit                    quiet_stretch  = 1'b0;

    min_coin_change_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_amount       (i_amount),
        .o_result_valid (o_result_valid),
        .o_min_count    (o_min_count),
        .o_unreachable  (o_unreachable),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // fewest coins for one amount, table filled from entry zero upward
    function automatic t_change predict_change(input logic [AMT_W-1:0] amt);
        t_change            res;
        int unsigned        used, best, c, v, k;
        bit                 found;
        logic [ENTRY_W-1:0] sub;
        used = (coin_count_q > MAX_COINS) ? MAX_COINS : coin_count_q;
        best_coins[0] = {1'b1, {CNT_W{1'b0}}};
        for (v = 1; v <= amt; v++) begin
            found = 1'b0;
            best  = 0;
            for (k = 0; k < used; k++) begin
                c = coin_q[k];
                // zero denominations and coins above v are skipped
                if (c != 0 && c <= v) begin
                    sub = best_coins[v - c];
                    if (sub[CNT_W] && (!found || sub[CNT_W-1:0] + 1 < best)) begin
                        best  = sub[CNT_W-1:0] + 1;
                        found = 1'b1;
                    end
                end
            end
            if (best > CNT_MAX)
                best = CNT_MAX;
            best_coins[v] = found ? {1'b1, best[CNT_W-1:0]} : '0;
        end
        if (best_coins[amt][CNT_W]) begin
            res.min_count   = best_coins[amt][CNT_W-1:0];
            res.unreachable = 1'b0;
        end else begin
            res.min_count   = '0;
            res.unreachable = 1'b1;
        end
        return res;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [COIN_W-1:0] data);
        case (idx)
            REG_COIN_A:     coin_q[0] = data;
            REG_COIN_B:     coin_q[1] = data;
            REG_COIN_C:     coin_q[2] = data;
            REG_COIN_D:     coin_q[3] = data;
            REG_COIN_COUNT: coin_count_q = data[CCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // mostly short gaps, a few long ones, none inside a quiet stretch
    function automatic int rand_gap();
        int r;
        if (quiet_stretch)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 12);
        return $urandom_range(20, 150);
    endfunction

    task automatic add_amount(input logic [AMT_W-1:0] amt);
        t_pending_op op;
        op        = '0;
        op.kind   = OP_AMOUNT;
        op.amount = amt;
        op.gap    = 16'(rand_gap());
        pending_q.push_back(op);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [COIN_W-1:0] data);
        t_pending_op op;
        op      = '0;
        op.kind = OP_WRITE;
        op.idx  = idx;
        op.data = data;
        op.gap  = 16'(rand_gap());
        pending_q.push_back(op);
    endtask

    task automatic add_drain();
        t_pending_op op;
        op      = '0;
        op.kind = OP_DRAIN;
        op.gap  = 16'(rand_gap());
        pending_q.push_back(op);
    endtask

    function automatic logic [AMT_W-1:0] rand_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return AMT_W'($urandom_range(0, 60));
        if (r < 95)
            return AMT_W'($urandom_range(61, 300));
        return AMT_W'($urandom_range(301, 1023));
    endfunction

    function automatic logic [COIN_W-1:0] rand_coin();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return COIN_W'($urandom_range(1, 30));
        if (r < 75)
            return COIN_W'($urandom_range(31, 200));
        if (r < 85)
            return COIN_W'($urandom_range(201, 1023));
        if (r < 95)
            return '0;
        return 10'd1023;
    endfunction

    // coin count mostly in range, sometimes zero or past the saturation point
    function automatic logic [COIN_W-1:0] rand_count_word();
        logic [CCNT_W-1:0] cnt;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 75)
            cnt = CCNT_W'($urandom_range(1, 4));
        else if (r < 85)
            cnt = '0;
        else
            cnt = CCNT_W'($urandom_range(5, 7));
        return {7'($urandom), cnt};
    endfunction

    // driver: one pending op at a time, amounts may be raised while busy,
    // register writes and drains wait for the block to be idle
    always @(posedge i_clk) begin : driver
        logic block_idle;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_valid  <= 1'b0;
            coin_q       = COIN_RST;
            coin_count_q = COIN_COUNT_RST;
            op_loaded    = 1'b0;
            op_issued    = 1'b0;
            gap_left     = 0;
        end else begin
            // retire accepted words
            if (start && !busy) begin
                expected_change_q.push_back(predict_change(i_amount));
                op_loaded = 1'b0;
                op_issued = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
                op_loaded = 1'b0;
                op_issued = 1'b0;
            end
            block_idle = !busy && !o_result_valid && expected_change_q.size() == 0;

            if (!op_loaded && pending_q.size() > 0) begin
                cur_op    = pending_q.pop_front();
                op_loaded = 1'b1;
                gap_left  = cur_op.gap;
            end

            if (op_loaded && !op_issued) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    case (cur_op.kind)
                        OP_AMOUNT: begin
                            i_amount  <= cur_op.amount;
                            op_issued = 1'b1;
                        end
                        OP_WRITE: if (block_idle) begin
                            i_cfg_index <= cur_op.idx;
                            i_cfg_data  <= cur_op.data;
                            op_issued   = 1'b1;
                        end
                        OP_DRAIN: if (block_idle) begin
                            op_loaded = 1'b0;
                        end
                        default: op_loaded = 1'b0;
                    endcase
                end
            end

            start       <= op_loaded && op_issued && cur_op.kind == OP_AMOUNT;
            i_cfg_valid <= op_loaded && op_issued && cur_op.kind == OP_WRITE;
        end
    end

    // monitor: every strobe is matched against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_change want;
        if (i_rst_n && o_result_valid) begin
            if (expected_change_q.size() == 0) begin
                report_mismatch("result word with no amount outstanding, min_count",
                                o_min_count, 0);
            end else begin
                want = expected_change_q.pop_front();
                if (o_min_count !== want.min_count)
                    report_mismatch("min_count", o_min_count, want.min_count);
                if (o_unreachable !== want.unreachable)
                    report_mismatch("unreachable", o_unreachable, want.unreachable);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int n_rand;
        int phase_len;
        int k;

        // reset denominations 25, 10, 5, 1, extremes of the amount
        add_amount(10'd0);
        add_amount(10'd1);
        add_amount(10'd4);
        add_amount(10'd30);
        add_amount(10'd99);
        add_amount(10'd1023);

        // largest coin, a zero denomination, gaps in reachability
        add_drain();
        add_write(REG_COIN_A, 10'd1023);
        add_write(REG_COIN_B, 10'd0);
        add_write(REG_COIN_C, 10'd7);
        add_write(REG_COIN_D, 10'd3);
        add_write(REG_COIN_COUNT, 10'd4);
        add_amount(10'd1023);
        add_amount(10'd1);
        add_amount(10'd11);
        add_amount(10'd14);
        add_amount(10'd1022);

        // no denominations in use
        add_drain();
        add_write(REG_COIN_COUNT, 10'h3F8);
        add_amount(10'd0);
        add_amount(10'd9);

        // count past the limit saturates
        add_drain();
        add_write(REG_COIN_A, 10'd1);
        add_write(REG_COIN_D, 10'd1023);
        add_write(REG_COIN_COUNT, 10'h3FF);
        add_amount(10'd1023);
        add_amount(10'd500);

        // a single even coin
        add_drain();
        add_write(REG_COIN_A, 10'd2);
        add_write(REG_COIN_COUNT, 10'h001);
        add_amount(10'd1023);
        add_amount(10'd1022);
        add_amount(10'd2);

        // writes outside the register map, then two coins with one at zero
        add_drain();
        add_write(CFG_IDX_SPARE_LO, 10'h3FF);
        add_write(CFG_IDX_SPARE_HI, 10'h000);
        add_write(REG_COIN_COUNT, 10'h002);
        add_amount(10'd6);

        // random phases, each under fresh denominations
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            quiet_stretch = ($urandom_range(0, 3) == 0);
            add_drain();
            add_write(REG_COIN_A, rand_coin());
            add_write(REG_COIN_B, rand_coin());
            add_write(REG_COIN_C, rand_coin());
            add_write(REG_COIN_D, rand_coin());
            add_write(REG_COIN_COUNT, rand_count_word());
            if ($urandom_range(0, 5) == 0)
                add_write(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                          COIN_W'($urandom));
            phase_len = $urandom_range(15, 30);
            for (k = 0; k < phase_len; k++) begin
                // hold off now and then until every result is in
                if ($urandom_range(0, 11) == 0)
                    add_drain();
                add_amount(rand_amount());
                n_rand++;
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || op_loaded)
            @(posedge i_clk);
        while (expected_change_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
